// File: rtl/sapq_pkg.sv
package sapq_pkg;

  localparam int CAPACITY = 8;
  localparam int KEY_W = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  // broadcast to every cell for one accepted item
  typedef struct packed {
    logic ins;
    logic rem;
    key_t new_key;
  } cell_ctrl_t;

  // what a cell shows its neighbors this cycle
  typedef struct packed {
    logic occ;
    logic lt;
    key_t key;
  } cell_link_t;

  // what a cell will hold after this cycle
  typedef struct packed {
    logic occ;
    key_t key;
  } cell_state_t;

  localparam cell_link_t LEFT_EDGE  = '{occ: 1'b1, lt: 1'b1, key: '0};
  localparam cell_link_t RIGHT_EDGE = '{occ: 1'b0, lt: 1'b0, key: '0};

endpackage

// File: rtl/sapq_cell.sv
module sapq_cell import sapq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  cell_link_t  left,
  input  cell_link_t  right,
  output cell_link_t  self_link,
  output cell_state_t nxt
);

  logic occ;
  key_t key;
  logic lt;

  // cell 0 holds the minimum; occupied cells ascend toward the far end
  assign lt = occ && (key < ctrl.new_key);

  assign self_link = '{occ: occ, lt: lt, key: key};

  always_comb begin
    nxt.occ = occ;
    nxt.key = key;
    if (ctrl.ins) begin
      nxt.occ = occ | left.occ;
      if (!lt) begin
        if (left.lt) begin
          nxt.key = ctrl.new_key;
        end else begin
          nxt.key = left.key;
        end
      end
    end else if (ctrl.rem) begin
      nxt.occ = right.occ;
      nxt.key = right.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= nxt.occ;
    end
  end

  always_ff @(posedge clk) begin
    key <= nxt.key;
  end

endmodule

// File: rtl/sorted_array_priority_queue_core.sv
// Each accepted item's result is registered at the output in the next cycle.
// Throughput: one item per cycle unless stalled; every cell compares and shifts in the same cycle.
// A result waiting under out_stall holds in_stall high until it is taken.
// Reset: synchronous, active high; clears all occupancy bits and the output valid.
// Stored keys have no reset and are only read once occupied.
module sorted_array_priority_queue_core import sapq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic signed [31:0] key_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] removed_key,
  output logic        removed_valid,
  output logic signed [31:0] min_key,
  output logic        is_empty,
  output logic        is_full,
  output logic [1:0]  error_code
);

  cell_ctrl_t  ctrl;
  cell_link_t  lnk     [CAPACITY];
  cell_link_t  left_in [CAPACITY];
  cell_link_t  right_in[CAPACITY];
  cell_state_t nx      [CAPACITY];

  logic accept;
  logic cur_empty;
  logic cur_full;
  logic [1:0] err_next;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cur_empty = !lnk[0].occ;
  assign cur_full  = lnk[CAPACITY-1].occ;

  assign ctrl.ins     = accept && (command == CMD_INSERT) && !cur_full;
  assign ctrl.rem     = accept && (command == CMD_REMOVE) && !cur_empty;
  assign ctrl.new_key = key_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_l_edge
      assign left_in[i] = LEFT_EDGE;
    end else begin : g_l_link
      assign left_in[i] = lnk[i-1];
    end
    if (i == CAPACITY-1) begin : g_r_edge
      assign right_in[i] = RIGHT_EDGE;
    end else begin : g_r_link
      assign right_in[i] = lnk[i+1];
    end
    sapq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_in[i]),
      .right     (right_in[i]),
      .self_link (lnk[i]),
      .nxt       (nx[i])
    );
  end

  always_comb begin
    err_next = ERR_OK;
    if (command == CMD_INSERT && cur_full) begin
      err_next = ERR_FULL;
    end else if (command == CMD_REMOVE && cur_empty) begin
      err_next = ERR_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_key   <= ctrl.rem ? lnk[0].key : '0;
      removed_valid <= ctrl.rem;
      min_key       <= nx[0].occ ? nx[0].key : '0;
      is_empty      <= !nx[0].occ;
      is_full       <= nx[CAPACITY-1].occ;
      error_code    <= err_next;
    end
  end

endmodule

// File: rtl/sapq_checker.sv
module sapq_checker import sapq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        command,
  input logic signed [31:0] key_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [31:0] removed_key,
  input logic        removed_valid,
  input logic signed [31:0] min_key,
  input logic        is_empty,
  input logic        is_full,
  input logic [1:0]  error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(removed_key) && $stable(min_key)
      && $stable(error_code) && $stable(removed_valid))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_remove_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && removed_valid |-> error_code == ERR_OK && !is_full)
    else $error("removal reported with error or full queue");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_EMPTY |-> is_empty && !removed_valid && min_key == '0)
    else $error("empty error with nonempty state");

  a_full_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_FULL |-> is_full && !is_empty)
    else $error("full error with nonfull state");

endmodule

bind sorted_array_priority_queue_core sapq_checker u_sapq_checker (.*);
